@@ hdl/rotdiv_pkg.sv @@
// ----------------------------------------------------------------------------
// rotdiv_pkg
// shared types, constants and the spread table for the rotating divider
// ----------------------------------------------------------------------------
package rotdiv_pkg;

	localparam int NUM_OUTPUTS_DEF = 8;
	localparam int CODE_W          = 6;
	localparam int LOOP_W          = 8;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 8;

	typedef logic [CODE_W-1:0] code_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RANGE_SEL   = 3'd0,
		REG_SPREAD_MODE = 3'd1,
		REG_LOOP_CLR    = 3'd2,
		REG_LOOP_LENGTH = 3'd3,
		REG_DOWNBEAT    = 3'd4,
		REG_HALF_GATE   = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic [1:0]        range_sel;
		logic              spread_mode;
		logic              loop_clr_en;
		logic [LOOP_W-1:0] loop_length;
		logic              downbeat_en;
		logic              half_gate;
	} cfg_t;

	function automatic code_t spread_code(input logic [2:0] idx);
		code_t res;
		case (idx)
			3'd0:    res = code_t'(0);
			3'd1:    res = code_t'(1);
			3'd2:    res = code_t'(2);
			3'd3:    res = code_t'(3);
			3'd4:    res = code_t'(5);
			3'd5:    res = code_t'(7);
			3'd6:    res = code_t'(11);
			default: res = code_t'(15);
		endcase
		return res;
	endfunction

endpackage

@@ hdl/rotdiv_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// rotdiv_cfg_regs
// configuration register file, written through a plain indexed write port
// ----------------------------------------------------------------------------
module rotdiv_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [rotdiv_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rotdiv_pkg::CFG_DATA_W-1:0] cfg_data,
	output rotdiv_pkg::cfg_t               cfg
);
	import rotdiv_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_idx_t'(cfg_index))
				REG_RANGE_SEL:   cfg_q.range_sel   <= cfg_data[1:0];
				REG_SPREAD_MODE: cfg_q.spread_mode <= cfg_data[0];
				REG_LOOP_CLR:    cfg_q.loop_clr_en <= cfg_data[0];
				REG_LOOP_LENGTH: cfg_q.loop_length <= cfg_data[LOOP_W-1:0];
				REG_DOWNBEAT:    cfg_q.downbeat_en <= cfg_data[0];
				REG_HALF_GATE:   cfg_q.half_gate   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ hdl/rotdiv_divisors.sv @@
// ----------------------------------------------------------------------------
// rotdiv_divisors
// per-output divisor codes from rotate, divide range and spread mode
// ----------------------------------------------------------------------------
module rotdiv_divisors #(
	parameter int NUM_OUTPUTS = rotdiv_pkg::NUM_OUTPUTS_DEF
) (
	input  rotdiv_pkg::cfg_t                         cfg,
	input  rotdiv_pkg::code_t                        rotate,
	output rotdiv_pkg::code_t [NUM_OUTPUTS-1:0]      codes
);
	import rotdiv_pkg::*;

	code_t kk [NUM_OUTPUTS];
	code_t lin_sum [NUM_OUTPUTS];

	always_comb begin
		for (int k = 0; k < NUM_OUTPUTS; k++) begin
			kk[k] = code_t'(k);
			lin_sum[k] = kk[k] + rotate;
			if (cfg.spread_mode) begin
				unique case (cfg.range_sel)
					2'd0: codes[k] = spread_code(lin_sum[k][2:0]);
					2'd1: codes[k] = ((kk[k] << 1) + code_t'(1) + rotate) & code_t'(15);
					2'd2: codes[k] = ((kk[k] << 2) + code_t'(3) + rotate) & code_t'(31);
					default: codes[k] = (kk[k] << 3) + code_t'(7) + rotate;
				endcase
			end else begin
				unique case (cfg.range_sel)
					2'd0: codes[k] = lin_sum[k] & code_t'(7);
					2'd1: codes[k] = (lin_sum[k] + code_t'(8)) & code_t'(15);
					2'd2: codes[k] = (lin_sum[k] + code_t'(16)) & code_t'(31);
					default: codes[k] = lin_sum[k] + code_t'(32);
				endcase
			end
		end
	end

endmodule

@@ hdl/rotdiv_core.sv @@
// ----------------------------------------------------------------------------
// rotdiv_core
// input register, edge detection, counter and gate update, result register
// ----------------------------------------------------------------------------
module rotdiv_core #(
	parameter int NUM_OUTPUTS = rotdiv_pkg::NUM_OUTPUTS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  rotdiv_pkg::cfg_t       cfg,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   clock_high,
	input  logic                   reset_high,
	input  rotdiv_pkg::code_t      rotate,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [NUM_OUTPUTS-1:0] gates
);
	import rotdiv_pkg::*;

	// input stage
	logic  valid_s1;
	logic  clock_high_s1;
	logic  reset_high_s1;
	code_t rotate_s1;

	// block state
	code_t             pc_q [NUM_OUTPUTS];
	logic [NUM_OUTPUTS-1:0] gl_q;
	logic              clock_was_high_q;
	logic              clock_was_low_q;
	logic              reset_was_high_q;
	logic [LOOP_W-1:0] loop_count_q;

	// result stage
	logic                   valid_s2;
	logic [NUM_OUTPUTS-1:0] gates_s2;

	code_t [NUM_OUTPUTS-1:0] dv;

	logic              adv_s1;
	logic              step;
	logic              rst_edge;
	logic              rise;
	logic              fall;
	logic [LOOP_W-1:0] loop_limit;
	logic [LOOP_W-1:0] lc0;
	logic [LOOP_W:0]   lc_inc;
	logic              loop_wrap;
	logic [LOOP_W-1:0] lc_nxt;

	code_t         pc0 [NUM_OUTPUTS];
	logic [CODE_W:0] pc_inc [NUM_OUTPUTS];
	code_t         pc_adv [NUM_OUTPUTS];
	code_t         half_hi [NUM_OUTPUTS];
	code_t         half_lo [NUM_OUTPUTS];
	code_t         pc_nxt [NUM_OUTPUTS];
	logic [NUM_OUTPUTS-1:0] gl_nxt;

	rotdiv_divisors #(
		.NUM_OUTPUTS(NUM_OUTPUTS)
	) u_divisors (
		.cfg    (cfg),
		.rotate (rotate_s1),
		.codes  (dv)
	);

	assign adv_s1   = !valid_s2 || !out_stall;
	assign step     = valid_s1 && adv_s1;
	assign in_stall = valid_s1 && !adv_s1;

	always_comb begin
		rst_edge  = reset_high_s1 && !reset_was_high_q;
		rise      = clock_high_s1 && !clock_was_high_q;
		fall      = !clock_high_s1 && !clock_was_low_q;
		if (cfg.loop_length != '0) begin
			loop_limit = cfg.loop_length;
		end else begin
			loop_limit = LOOP_W'(16) << cfg.range_sel;
		end
		lc0       = rst_edge ? '0 : loop_count_q;
		lc_inc    = {1'b0, lc0} + (LOOP_W+1)'(1);
		loop_wrap = rise && cfg.loop_clr_en && (lc_inc >= {1'b0, loop_limit});
		if (rise) begin
			if (!cfg.loop_clr_en || loop_wrap) begin
				lc_nxt = '0;
			end else begin
				lc_nxt = lc_inc[LOOP_W-1:0];
			end
		end else begin
			lc_nxt = lc0;
		end

		for (int k = 0; k < NUM_OUTPUTS; k++) begin
			pc0[k]     = rst_edge ? '0 : pc_q[k];
			pc_inc[k]  = {1'b0, pc0[k]} + (CODE_W+1)'(1);
			pc_adv[k]  = (pc_inc[k] > {1'b0, dv[k]}) ? '0 : pc_inc[k][CODE_W-1:0];
			half_hi[k] = (dv[k] >> 1) + code_t'(1);
			half_lo[k] = code_t'(({1'b0, dv[k]} + (CODE_W+1)'(1)) >> 1);
			gl_nxt[k]  = gl_q[k];
			pc_nxt[k]  = pc0[k];
			if (rise) begin
				if (cfg.downbeat_en) begin
					if (pc0[k] == '0) gl_nxt[k] = 1'b1;
					if (cfg.half_gate) begin
						if (pc0[k] == half_hi[k]) gl_nxt[k] = 1'b0;
					end else begin
						pc_nxt[k] = pc_adv[k];
					end
				end else if (cfg.half_gate) begin
					if (pc0[k] == half_hi[k]) gl_nxt[k] = 1'b1;
					if (pc0[k] == '0) gl_nxt[k] = 1'b0;
				end else begin
					pc_nxt[k] = pc_adv[k];
					if (pc_adv[k] == '0) gl_nxt[k] = 1'b1;
				end
				if (loop_wrap) pc_nxt[k] = '0;
			end else if (fall) begin
				if (cfg.half_gate) begin
					if (pc0[k] == half_lo[k]) gl_nxt[k] = !cfg.downbeat_en;
					pc_nxt[k] = pc_adv[k];
				end else begin
					gl_nxt[k] = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1         <= 1'b0;
			valid_s2         <= 1'b0;
			gl_q             <= '0;
			clock_was_high_q <= 1'b0;
			clock_was_low_q  <= 1'b0;
			reset_was_high_q <= 1'b0;
			loop_count_q     <= '0;
			for (int k = 0; k < NUM_OUTPUTS; k++) pc_q[k] <= '0;
		end else begin
			if (!in_stall) valid_s1 <= in_valid;
			if (adv_s1) valid_s2 <= valid_s1;
			if (step) begin
				gl_q             <= gl_nxt;
				clock_was_high_q <= clock_high_s1;
				clock_was_low_q  <= !clock_high_s1;
				reset_was_high_q <= reset_high_s1;
				loop_count_q     <= lc_nxt;
				for (int k = 0; k < NUM_OUTPUTS; k++) pc_q[k] <= pc_nxt[k];
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			clock_high_s1 <= clock_high;
			reset_high_s1 <= reset_high;
			rotate_s1     <= rotate;
		end
		if (step) gates_s2 <= gl_nxt;
	end

	assign out_valid = valid_s2;
	assign gates     = gates_s2;

endmodule

@@ hdl/rotating_clock_divider.sv @@
// ----------------------------------------------------------------------------
// rotating_clock_divider
// eight-output rotating clock divider driven by sampled clock and reset levels
// ----------------------------------------------------------------------------
// Each input transfer carries one sample: clock level, reset level and a
// rotate amount. Each sample yields exactly one output transfer whose gates
// word holds the level of the eight divided outputs after that sample.
// Both channels use valid/stall; a transfer happens on a clock edge with
// valid high and stall low. Configuration registers are written through
// cfg_wr_en/cfg_index/cfg_data; the user must do so only while no sample
// is in flight, since the block does not enforce it. A sample passes
// through the input register, where the edge-detect and counter logic
// works on it, and then the result register, which drives out_valid.
// Throughput is one sample per cycle while the receiver does not stall;
// the eight phase counters update in parallel. When the receiver stalls,
// the result register holds and the input register keeps one more sample;
// in_stall rises only once both are full. Reset clears the configuration,
// the counters, the gate levels, the edge flags and the loop count; the
// first samples after reset then act as clock edges.
// ----------------------------------------------------------------------------
module rotating_clock_divider #(
	parameter int NUM_OUTPUTS = rotdiv_pkg::NUM_OUTPUTS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [rotdiv_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rotdiv_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              clock_high,
	input  logic                              reset_high,
	input  logic [rotdiv_pkg::CODE_W-1:0]     rotate,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [NUM_OUTPUTS-1:0]            gates
);
	import rotdiv_pkg::*;

	cfg_t cfg;

	rotdiv_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	rotdiv_core #(
		.NUM_OUTPUTS(NUM_OUTPUTS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.clock_high (clock_high),
		.reset_high (reset_high),
		.rotate     (rotate),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.gates      (gates)
	);

endmodule

@@ hdl/rotdiv_checker.sv @@
// ----------------------------------------------------------------------------
// rotdiv_checker
// port-level checks on the rotating divider's transfer channels
// ----------------------------------------------------------------------------
module rotdiv_checker #(
	parameter int NUM_OUTPUTS = rotdiv_pkg::NUM_OUTPUTS_DEF
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_stall,
	input logic                   out_valid,
	input logic                   out_stall,
	input logic [NUM_OUTPUTS-1:0] gates
);

	// held result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(gates))
		else $error("stalled output transfer changed");

	// input only backs up behind a stalled, full output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output backpressure");

	// an empty output stage never holds off the input
	a_no_stall_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled while output empty");

	// a stall never rises without a pending input sample
	a_stall_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(in_valid) || $past(in_stall))
		else $error("input stall with nothing held");

endmodule

bind rotating_clock_divider rotdiv_checker #(
	.NUM_OUTPUTS(NUM_OUTPUTS)
) u_rotdiv_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.gates     (gates)
);

@@ tb/rotating_clock_divider_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotating_clock_divider_tb
// self-checking bench for the eight-output rotating clock divider
// ----------------------------------------------------------------------------
// Sends sampled clock/reset/rotate transfers through the valid/stall input
// and predicts the gates word of every sample with an independent model of
// the counters, edge flags and loop count. Each output transfer is checked
// against the oldest prediction. An opening table of samples runs in the
// reset configuration, then a series of register settings (fixed extremes
// and random ones) each gets a run of mostly well-formed clock sequences
// with random rotate and reset pulses. Sender bursts and receiver stalls
// are random, with long receiver hold-offs to fill the block.
// ----------------------------------------------------------------------------
module rotating_clock_divider_tb;
	import rotdiv_pkg::*;

	localparam int LIMIT_CYCLES = 300000;
	localparam int SETTLE_CYCLES = 8;

	typedef struct {
		bit          ck;
		bit          rs;
		logic [5:0]  rot;
		bit          known;
		logic [7:0]  gates;
	} sample_row_t;

	typedef struct {
		cfg_t setup;
		int   items;
		int   rst_odds;
	} phase_t;

	localparam int SPREAD_STEPS [8] = '{0, 1, 2, 3, 5, 7, 11, 15};

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic                  clock_high = 1'b0;
	logic                  reset_high = 1'b0;
	logic [CODE_W-1:0]     rotate = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [7:0]            gates;

	rotating_clock_divider u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.clock_high (clock_high),
		.reset_high (reset_high),
		.rotate     (rotate),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.gates      (gates)
	);

	always #2 clk = ~clk;

	// predictor state
	cfg_t       setup = '0;
	code_t      div_cnt [8];
	logic [7:0] lvl_q = '0;
	bit         saw_high = 1'b0;
	bit         saw_low = 1'b0;
	bit         rst_seen = 1'b0;
	logic [7:0] edges_in_loop = '0;

	logic [7:0] gates_due [$];
	int         errors = 0;
	int         cycles = 0;
	int         burst_left = 0;

	sample_row_t opening_rows [22] = '{
		'{1'b0, 1'b0, 6'd0,  1'b1, 8'h00},
		'{1'b1, 1'b0, 6'd0,  1'b1, 8'h01},
		'{1'b1, 1'b0, 6'd0,  1'b1, 8'h01},
		'{1'b0, 1'b0, 6'd0,  1'b1, 8'h00},
		'{1'b0, 1'b0, 6'd0,  1'b1, 8'h00},
		'{1'b1, 1'b0, 6'd0,  1'b0, 8'h00},
		'{1'b0, 1'b0, 6'd63, 1'b0, 8'h00},
		'{1'b1, 1'b0, 6'd63, 1'b0, 8'h00},
		'{1'b0, 1'b0, 6'd63, 1'b0, 8'h00},
		'{1'b1, 1'b0, 6'd63, 1'b0, 8'h00},
		'{1'b0, 1'b0, 6'd63, 1'b0, 8'h00},
		'{1'b1, 1'b1, 6'd63, 1'b0, 8'h00},
		'{1'b0, 1'b1, 6'd63, 1'b0, 8'h00},
		'{1'b1, 1'b1, 6'd63, 1'b0, 8'h00},
		'{1'b0, 1'b0, 6'd21, 1'b0, 8'h00},
		'{1'b1, 1'b0, 6'd42, 1'b0, 8'h00},
		'{1'b0, 1'b0, 6'd42, 1'b0, 8'h00},
		'{1'b1, 1'b0, 6'd0,  1'b0, 8'h00},
		'{1'b0, 1'b1, 6'd0,  1'b0, 8'h00},
		'{1'b1, 1'b0, 6'd63, 1'b0, 8'h00},
		'{1'b0, 1'b0, 6'd7,  1'b0, 8'h00},
		'{1'b1, 1'b0, 6'd56, 1'b0, 8'h00}
	};

	phase_t fixed_phases [6] = '{
		'{'{2'd3, 1'b1, 1'b1, 8'd0,   1'b1, 1'b1}, 120, 40},
		'{'{2'd0, 1'b1, 1'b1, 8'd1,   1'b0, 1'b1}, 100, 40},
		'{'{2'd1, 1'b1, 1'b0, 8'd255, 1'b1, 1'b0}, 100, 40},
		'{'{2'd2, 1'b1, 1'b1, 8'd7,   1'b0, 1'b0}, 100, 40},
		'{'{2'd3, 1'b0, 1'b1, 8'd255, 1'b0, 1'b1}, 850, 0},
		'{'{2'd0, 1'b0, 1'b0, 8'd0,   1'b0, 1'b0}, 60,  20}
	};

	function automatic int top_code();
		return (1 << (int'(setup.range_sel) + 3)) - 1;
	endfunction

	function automatic int wrap_code(int k, int rot);
		if (setup.spread_mode) begin
			case (setup.range_sel)
				2'd1:    return (2 * k + 1 + rot) & 15;
				2'd2:    return (4 * k + 3 + rot) & 31;
				2'd3:    return (8 * k + 7 + rot) & 63;
				default: return SPREAD_STEPS[(k + rot) & 7];
			endcase
		end
		return (k + rot + (((1 << int'(setup.range_sel)) >> 1) << 3)) & top_code();
	endfunction

	function automatic void bump(int k, int w);
		if (int'(div_cnt[k]) + 1 > w)
			div_cnt[k] = '0;
		else
			div_cnt[k] = div_cnt[k] + 1'b1;
	endfunction

	function automatic void clear_counters();
		foreach (div_cnt[k])
			div_cnt[k] = '0;
	endfunction

	function automatic logic [7:0] next_gates(bit ck, bit rs, int rot);
		int wrap [8];
		int lim;
		int cnt;
		for (int k = 0; k < 8; k++)
			wrap[k] = wrap_code(k, rot);
		if (rs) begin
			if (!rst_seen) begin
				rst_seen = 1'b1;
				clear_counters();
				edges_in_loop = '0;
			end
		end else begin
			rst_seen = 1'b0;
		end
		if (ck) begin
			saw_low = 1'b0;
			if (!saw_high) begin
				saw_high = 1'b1;
				if (setup.downbeat_en) begin
					for (int k = 0; k < 8; k++)
						if (div_cnt[k] == 0) lvl_q[k] = 1'b1;
					if (setup.half_gate) begin
						for (int k = 0; k < 8; k++)
							if (int'(div_cnt[k]) == wrap[k] / 2 + 1) lvl_q[k] = 1'b0;
					end else begin
						for (int k = 0; k < 8; k++)
							bump(k, wrap[k]);
					end
				end else if (setup.half_gate) begin
					for (int k = 0; k < 8; k++)
						if (int'(div_cnt[k]) == wrap[k] / 2 + 1) lvl_q[k] = 1'b1;
					for (int k = 0; k < 8; k++)
						if (div_cnt[k] == 0) lvl_q[k] = 1'b0;
				end else begin
					for (int k = 0; k < 8; k++) begin
						bump(k, wrap[k]);
						if (div_cnt[k] == 0) lvl_q[k] = 1'b1;
					end
				end
				if (setup.loop_clr_en) begin
					lim = (setup.loop_length != 0) ? int'(setup.loop_length)
						: 2 * (top_code() + 1);
					cnt = int'(edges_in_loop) + 1;
					if (cnt >= lim) begin
						cnt = 0;
						clear_counters();
					end
					edges_in_loop = 8'(cnt);
				end else begin
					edges_in_loop = '0;
				end
			end
		end else begin
			saw_high = 1'b0;
			if (!saw_low) begin
				saw_low = 1'b1;
				if (setup.half_gate) begin
					for (int k = 0; k < 8; k++)
						if (int'(div_cnt[k]) == (wrap[k] + 1) / 2) lvl_q[k] = !setup.downbeat_en;
					for (int k = 0; k < 8; k++)
						bump(k, wrap[k]);
				end else begin
					lvl_q = '0;
				end
			end
		end
		return lvl_q;
	endfunction

	task automatic report(input string what);
		$display("mismatch at cycle %0d: %s", cycles, what);
		errors++;
	endtask

	task automatic send_sample(input bit ck, input bit rs, input logic [5:0] rot,
			input bit known, input logic [7:0] want);
		int gap;
		logic [7:0] due;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid   <= 1'b1;
		clock_high <= ck;
		reset_high <= rs;
		rotate     <= rot;
		do @(posedge clk); while (in_stall);
		due = next_gates(ck, rs, int'(rot));
		gates_due.push_back(known ? want : due);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [7:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
	endtask

	task automatic apply_setup(input cfg_t c);
		in_valid <= 1'b0;
		while (gates_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		write_reg(REG_RANGE_SEL, 8'(c.range_sel));
		write_reg(REG_SPREAD_MODE, 8'(c.spread_mode));
		write_reg(REG_LOOP_CLR, 8'(c.loop_clr_en));
		write_reg(REG_LOOP_LENGTH, c.loop_length);
		write_reg(REG_DOWNBEAT, 8'(c.downbeat_en));
		write_reg(REG_HALF_GATE, 8'(c.half_gate));
		cfg_wr_en <= 1'b0;
		setup = c;
	endtask

	task automatic run_phase(input phase_t ph);
		bit ck;
		bit rs;
		logic [5:0] rot;
		ck  = saw_high;
		rs  = rst_seen;
		rot = 6'($urandom_range(0, 63));
		apply_setup(ph.setup);
		for (int i = 0; i < ph.items; i++) begin
			if ($urandom_range(0, 9) == 0) begin
				ck  = 1'($urandom_range(0, 1));
				rot = 6'($urandom_range(0, 63));
				if (ph.rst_odds != 0) rs = 1'($urandom_range(0, 1));
			end else begin
				if ($urandom_range(0, 3) != 0) ck = !ck;
				if (rs) rs = 1'($urandom_range(0, 1));
				else if (ph.rst_odds != 0 && $urandom_range(1, ph.rst_odds) == 1) rs = 1'b1;
				if ($urandom_range(0, 9) == 0) rot = 6'($urandom_range(0, 63));
			end
			send_sample(ck, rs, rot, 1'b0, 8'h00);
		end
	endtask

	function automatic cfg_t random_setup();
		cfg_t c;
		c.range_sel   = 2'($urandom_range(0, 3));
		c.spread_mode = 1'($urandom_range(0, 1));
		c.loop_clr_en = 1'($urandom_range(0, 1));
		c.loop_length = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
			: 8'($urandom_range(0, 20));
		c.downbeat_en = 1'($urandom_range(0, 1));
		c.half_gate   = 1'($urandom_range(0, 1));
		return c;
	endfunction

	initial begin
		phase_t ph;
		clear_counters();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (opening_rows[i])
			send_sample(opening_rows[i].ck, opening_rows[i].rs, opening_rows[i].rot,
				opening_rows[i].known, opening_rows[i].gates);
		foreach (fixed_phases[i])
			run_phase(fixed_phases[i]);
		repeat (3) begin
			ph.setup    = random_setup();
			ph.items    = 120;
			ph.rst_odds = 30;
			run_phase(ph);
		end
		in_valid <= 1'b0;
		while (gates_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("[rotating_clock_divider] OK");
		else
			$display("[rotating_clock_divider] ERROR");
		$finish;
	end

	// output checker
	always @(posedge clk) begin
		logic [7:0] want;
		if (arst_n && out_valid && !out_stall) begin
			if (gates_due.size() == 0) begin
				report($sformatf("unexpected transfer, gates %h", gates));
			end else begin
				want = gates_due.pop_front();
				if (gates !== want)
					report($sformatf("gates %h, predicted %h", gates, want));
			end
		end
	end

	// receiver stall pattern with long hold-offs
	int drained = 0;
	int next_hold = 300;
	int hold_left = 0;
	int mode_left = 0;
	int stall_mode = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) drained = drained + 1;
			if (hold_left > 0) begin
				hold_left = hold_left - 1;
				out_stall <= 1'b1;
			end else if (drained >= next_hold) begin
				hold_left = 150;
				next_hold = next_hold + 700;
				out_stall <= 1'b1;
			end else begin
				if (mode_left == 0) begin
					stall_mode = $urandom_range(0, 2);
					mode_left = $urandom_range(10, 80);
				end else begin
					mode_left = mode_left - 1;
				end
				case (stall_mode)
					0:       out_stall <= 1'b0;
					1:       out_stall <= ($urandom_range(0, 1) == 1);
					default: out_stall <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		cycles = cycles + 1;
		if (cycles == LIMIT_CYCLES) begin
			$display("[rotating_clock_divider] ERROR");
			$finish;
		end
	end

endmodule

@@ filelist.f @@
hdl/rotdiv_pkg.sv
hdl/rotdiv_cfg_regs.sv
hdl/rotdiv_divisors.sv
hdl/rotdiv_core.sv
hdl/rotating_clock_divider.sv
hdl/rotdiv_checker.sv
tb/rotating_clock_divider_tb.sv
